[rtl/tbdr_pkg.sv]
// ---------------------------------------------------------------------------
// tbdr_pkg: shared types and constants for the two-button debouncer
// Phase and button codes, op and register codes, stream payload layouts and
// reset defaults for the configuration registers.
// ---------------------------------------------------------------------------
package tbdr_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int HOLD_BITS_DEF  = 8;

  localparam int DELAY_W = 16;
  localparam int POLLS_W = 8;

  localparam logic [DELAY_W-1:0] BOUNCE_DELAY_RST = 16'd255;
  localparam logic [DELAY_W-1:0] POLL_PERIOD_RST  = 16'd255;
  localparam logic [POLLS_W-1:0] HOLD_POLLS_RST   = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_BOUNCE_IN  = 2'd1,
    PH_HELD       = 2'd2,
    PH_BOUNCE_OUT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2,
    BTN_RSVD  = 2'd3
  } button_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_BOUNCE_DELAY = 2'd0,
    CFG_POLL_PERIOD  = 2'd1,
    CFG_HOLD_POLLS   = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_reg_t;

  // Input request payload, lowest bit first: edge_left, edge_right,
  // level_left, level_right.
  typedef struct packed {
    logic [3:0] pad;
    logic       level_right;
    logic       level_left;
    logic       edge_right;
    logic       edge_left;
  } in_data_t;

  // Result payload, lowest bits first: button_read, busy_res, repeat_fired.
  typedef struct packed {
    logic [3:0] pad;
    logic       repeat_fired;
    logic       busy_res;
    logic [1:0] button_read;
  } result_t;

endpackage

[rtl/two_button_debounce_with_repeat.sv]
// ---------------------------------------------------------------------------
// two_button_debounce_with_repeat
// Debounces a left and a right push button and re-latches a held button
// after a programmable number of polls. One result per input request.
// ---------------------------------------------------------------------------
// Each result is registered. Throughput: one request per cycle while the
// skid entry is empty; all state updates in a single pass of next-state
// logic, with a two-entry output buffer so input keeps flowing while one
// result waits. rst (synchronous) returns to idle, clears both buttons, the
// counters and the output buffer, and loads register defaults.
module two_button_debounce_with_repeat
  import tbdr_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int HOLD_BITS  = HOLD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // edge_left, edge_right, level_left, level_right
  input  logic [1:0]          s_tuser,   // op
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // button_read[1:0], busy_res, repeat_fired
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [DELAY_W-1:0]  cfg_data
);

  logic [DELAY_W-1:0] bounce_delay;
  logic [DELAY_W-1:0] poll_period;
  logic [POLLS_W-1:0] hold_polls;

  phase_t                phase, phase_next;
  button_t               active_button, active_button_next;
  button_t               latched_button, latched_button_next;
  logic [HOLD_BITS-1:0]  hold_count, hold_count_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [TIMER_BITS-1:0] reload_value, reload_value_next;
  logic                  fired;

  in_data_t  in_d;
  op_t       op;
  logic      in_acc;
  logic      released;
  result_t   res;

  result_t   out_data;
  logic      out_valid;
  result_t   skid_data;
  logic      skid_valid;

  assign in_d      = in_data_t'(s_tdata);
  assign op        = op_t'(s_tuser);
  assign s_tready  = !skid_valid;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_delay <= BOUNCE_DELAY_RST;
      poll_period  <= POLL_PERIOD_RST;
      hold_polls   <= HOLD_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BOUNCE_DELAY: bounce_delay <= cfg_data;
        CFG_POLL_PERIOD:  poll_period  <= cfg_data;
        CFG_HOLD_POLLS:   hold_polls   <= cfg_data[POLLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (active_button)
      BTN_LEFT:  released = in_d.level_left;
      BTN_RIGHT: released = in_d.level_right;
      default:   released = 1'b1;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_next          = phase;
    active_button_next  = active_button;
    latched_button_next = latched_button;
    hold_count_next     = hold_count;
    countdown_next      = countdown;
    reload_value_next   = reload_value;
    fired               = 1'b0;
    case (op)
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (countdown <= TIMER_BITS'(1)) begin
            case (phase)
              PH_BOUNCE_IN: begin
                reload_value_next = TIMER_BITS'(poll_period);
                countdown_next    = TIMER_BITS'(poll_period);
                phase_next        = PH_HELD;
              end
              PH_HELD: begin
                if (released) begin
                  reload_value_next = TIMER_BITS'(bounce_delay);
                  countdown_next    = TIMER_BITS'(bounce_delay);
                  phase_next        = PH_BOUNCE_OUT;
                end else if (hold_count == HOLD_BITS'(hold_polls)) begin
                  // Held long enough: latch the button again.
                  hold_count_next     = '0;
                  latched_button_next = active_button;
                  countdown_next      = reload_value;
                  fired               = 1'b1;
                end else begin
                  hold_count_next = hold_count + HOLD_BITS'(1);
                  countdown_next  = reload_value;
                end
              end
              PH_BOUNCE_OUT: begin
                countdown_next     = '0;
                reload_value_next  = '0;
                phase_next         = PH_IDLE;
                active_button_next = BTN_NONE;
              end
              default: ;
            endcase
          end else begin
            countdown_next = countdown - TIMER_BITS'(1);
          end
        end
      end
      OP_EDGE: begin
        // Only a single-button edge while idle starts a press.
        if (phase == PH_IDLE && (in_d.edge_left ^ in_d.edge_right)) begin
          latched_button_next = in_d.edge_left ? BTN_LEFT : BTN_RIGHT;
          active_button_next  = in_d.edge_left ? BTN_LEFT : BTN_RIGHT;
          hold_count_next     = '0;
          reload_value_next   = TIMER_BITS'(bounce_delay);
          countdown_next      = TIMER_BITS'(bounce_delay);
          phase_next          = PH_BOUNCE_IN;
          fired               = 1'b1;
        end
      end
      OP_READ: begin
        latched_button_next = BTN_NONE;
      end
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    res              = '0;
    res.button_read  = (op == OP_READ) ? latched_button : BTN_NONE;
    res.busy_res     = (phase_next != PH_IDLE);
    res.repeat_fired = fired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_button  <= BTN_NONE;
      latched_button <= BTN_NONE;
      hold_count     <= '0;
      countdown      <= '0;
      reload_value   <= '0;
    end else if (in_acc) begin
      phase          <= phase_next;
      active_button  <= active_button_next;
      latched_button <= latched_button_next;
      hold_count     <= hold_count_next;
      countdown      <= countdown_next;
      reload_value   <= reload_value_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_acc) begin
        out_data <= res;
      end
    end else if (in_acc) begin
      skid_data <= res;
    end
  end

endmodule

[tb/sv/two_button_debounce_with_repeat_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_button_debounce_with_repeat_tb
// Drives tick, edge, read and no-op requests into the debouncer under several
// register settings. A scoreboard class predicts each result from its own
// copy of the debounce state and compares every result field by field.
// ---------------------------------------------------------------------------
module two_button_debounce_with_repeat_tb;
  import tbdr_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 200;

  class debounce_scoreboard;
    logic [DELAY_W-1:0] bounce_delay;
    logic [DELAY_W-1:0] poll_period;
    logic [POLLS_W-1:0] hold_polls;
    phase_t             phase;
    button_t            active_btn;
    button_t            latched_btn;
    logic [POLLS_W-1:0] hold_count;
    logic [DELAY_W-1:0] countdown;
    logic [DELAY_W-1:0] reload_value;
    result_t            expected_q[$];
    int                 mismatches;

    function new();
      bounce_delay = BOUNCE_DELAY_RST;
      poll_period  = POLL_PERIOD_RST;
      hold_polls   = HOLD_POLLS_RST;
      phase        = PH_IDLE;
      active_btn   = BTN_NONE;
      latched_btn  = BTN_NONE;
      hold_count   = '0;
      countdown    = '0;
      reload_value = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DELAY_W-1:0] value);
      case (idx)
        CFG_BOUNCE_DELAY: bounce_delay = value;
        CFG_POLL_PERIOD:  poll_period  = value;
        CFG_HOLD_POLLS:   hold_polls   = value[POLLS_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_countdown(logic [DELAY_W-1:0] value);
      reload_value = value;
      countdown    = value;
    endfunction

    // Handles an expired countdown; returns 1 when a held button is latched again.
    function bit countdown_expired(logic lvl_left, logic lvl_right);
      logic released;
      released = 1'b1;
      if (active_btn == BTN_LEFT) begin
        released = lvl_left;
      end else if (active_btn == BTN_RIGHT) begin
        released = lvl_right;
      end
      countdown_expired = 1'b0;
      case (phase)
        PH_BOUNCE_IN: begin
          load_countdown(poll_period);
          phase = PH_HELD;
        end
        PH_HELD: begin
          if (released) begin
            load_countdown(bounce_delay);
            phase = PH_BOUNCE_OUT;
          end else if (hold_count == hold_polls) begin
            hold_count        = '0;
            latched_btn       = active_btn;
            countdown         = reload_value;
            countdown_expired = 1'b1;
          end else begin
            hold_count = hold_count + 1'b1;
            countdown  = reload_value;
          end
        end
        PH_BOUNCE_OUT: begin
          countdown    = '0;
          reload_value = '0;
          phase        = PH_IDLE;
          active_btn   = BTN_NONE;
        end
        default: ;
      endcase
    endfunction

    function void note_request(op_t op, in_data_t d);
      result_t r;
      r = '0;
      case (op)
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (countdown <= 1) begin
              r.repeat_fired = countdown_expired(d.level_left, d.level_right);
            end else begin
              countdown = countdown - 1'b1;
            end
          end
        end
        OP_EDGE: begin
          // Edges are masked while a press is in progress.
          if (phase == PH_IDLE && (d.edge_left ^ d.edge_right)) begin
            active_btn  = d.edge_left ? BTN_LEFT : BTN_RIGHT;
            latched_btn = active_btn;
            hold_count  = '0;
            load_countdown(bounce_delay);
            phase          = PH_BOUNCE_IN;
            r.repeat_fired = 1'b1;
          end
        end
        OP_READ: begin
          r.button_read = latched_btn;
          latched_btn   = BTN_NONE;
        end
        default: ;
      endcase
      r.busy_res = (phase != PH_IDLE);
      expected_q.push_back(r);
    endfunction

    function void flag_mismatch(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected read=%0d busy=%0d fired=%0d", $time, what,
                 want.button_read, want.busy_res, want.repeat_fired);
        $display("%0t %s: actual   read=%0d busy=%0d fired=%0d", $time, what,
                 got.button_read, got.busy_res, got.repeat_fired);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no request", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.button_read !== want.button_read || got.busy_res !== want.busy_res ||
          got.repeat_fired !== want.repeat_fired) begin
        flag_mismatch("field mismatch", want, got);
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata   = '0;   // edge_left, edge_right, level_left, level_right
  logic [1:0]         s_tuser   = '0;   // op
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [7:0]         m_tdata;          // button_read[1:0], busy_res, repeat_fired
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [DELAY_W-1:0] cfg_data  = '0;

  debounce_scoreboard sb;
  int  burst_left    = 0;
  int  items_sent    = 0;
  int  cycle_count   = 0;
  int  rx_count      = 0;
  int  rx_mode       = 0;
  int  hold_off_left = 0;
  bit  hold_off_req  = 1'b0;

  two_button_debounce_with_repeat dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(result_t'(m_tdata));
      if (s_tvalid && s_tready) sb.note_request(op_t'(s_tuser), in_data_t'(s_tdata));
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  // Result side: random stall patterns, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_req || hold_off_left > 0) begin
      if (hold_off_req) begin
        hold_off_left = HOLD_OFF_CYCLES;
        hold_off_req  = 1'b0;
      end
      hold_off_left = hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (rx_count == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_count = $urandom_range(8, 64);
      end
      rx_count = rx_count - 1;
      case (rx_mode)
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= 1'b1;
      endcase
    end
  end

  task automatic send_request(input op_t op, input logic el, input logic er,
                              input logic ll, input logic lr);
    in_data_t d;
    int       gap;
    d             = '0;
    d.edge_left   = el;
    d.edge_right  = er;
    d.level_left  = ll;
    d.level_right = lr;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  // The first edge lets the monitor note the last request before the count is read.
  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_reg_t idx, input logic [DELAY_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One press of a random button: edge, a hold with occasional reads, stray edges
  // and pin bounces, then the release.
  task automatic press_sequence(input int min_hold, input int max_hold);
    logic right;
    logic rnd;
    int   hold_len;
    int   pick;
    right    = 1'($urandom_range(0, 1));
    rnd      = 1'($urandom_range(0, 1));
    send_request(OP_EDGE, !right, right, right ? rnd : 1'b0, right ? 1'b0 : rnd);
    hold_len = $urandom_range(min_hold, max_hold);
    for (int i = 0; i < hold_len; i++) begin
      pick = $urandom_range(0, 15);
      rnd  = 1'($urandom_range(0, 1));
      if (pick == 0) begin
        send_request(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rnd, rnd);
      end else if (pick == 1) begin
        send_request(OP_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick == 2) begin
        send_request(OP_TICK, 1'b0, 1'b0, right ? rnd : 1'b1, right ? 1'b1 : rnd);
      end else begin
        send_request(OP_TICK, 1'b0, 1'b0, right ? rnd : 1'b0, right ? 1'b0 : rnd);
      end
    end
    for (int i = $urandom_range(1, 12); i > 0; i--) begin
      rnd = 1'($urandom_range(0, 1));
      send_request(OP_TICK, 1'b0, 1'b0, right ? rnd : 1'b1, right ? 1'b1 : rnd);
    end
    if ($urandom_range(0, 1)) send_request(OP_READ, 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic run_phase(input logic [DELAY_W-1:0] bd, input logic [DELAY_W-1:0] pp,
                           input logic [POLLS_W-1:0] hp, input int n, input int min_hold,
                           input int max_hold, input bit hold_off);
    int start;
    wait_drained();
    program_reg(CFG_BOUNCE_DELAY, bd);
    program_reg(CFG_POLL_PERIOD, pp);
    // Upper bits of the hold limit write carry noise that the block must drop.
    program_reg(CFG_HOLD_POLLS, {8'($urandom_range(0, 255)), hp});
    if (hold_off) hold_off_req = 1'b1;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) < 7) begin
        press_sequence(min_hold, max_hold);
      end else begin
        send_request(op_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle behavior and ignored requests.
    send_request(OP_READ, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(OP_EDGE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_request(OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(OP_NOP, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // Zero delay and period expire on the first tick; the unused index does nothing.
    program_reg(CFG_BOUNCE_DELAY, '0);
    program_reg(CFG_POLL_PERIOD, '0);
    program_reg(CFG_HOLD_POLLS, '0);
    program_reg(CFG_NONE, '1);
    send_request(OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b1);
    send_request(OP_EDGE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(OP_READ, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_READ, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_READ, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(OP_EDGE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(OP_READ, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(OP_NOP, 1'b0, 1'b0, 1'b0, 1'b0);

    run_phase(16'd1, 16'd1, 8'd0, 150, 1, 20, 1'b0);
    run_phase(16'd2, 16'd3, 8'd2, 150, 1, 40, 1'b1);
    run_phase(16'd1, 16'd1, 8'd255, 260, 260, 300, 1'b0);
    run_phase(16'd0, 16'd0, 8'd1, 120, 1, 30, 1'b0);
    run_phase(16'd5, 16'd2, 8'd4, 120, 1, 60, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 8'd255, 60, 1, 40, 1'b0);

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[two_button_debounce_with_repeat.f]
rtl/tbdr_pkg.sv
rtl/two_button_debounce_with_repeat.sv
tb/sv/two_button_debounce_with_repeat_tb.sv
